// File: hdl/saxpy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saxpy_pkg
// Shared constants and pipeline types for the single precision axpy unit.
// ----------------------------------------------------------------------------
package saxpy_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX = 8'hFF;

    // special-case classification carried down the pipe
    typedef struct packed {
        logic nan;
        logic inf;
        logic sign;
    } spec_t;

endpackage
`default_nettype wire

// File: hdl/single_precision_axpy_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// single_precision_axpy_unit
// Streaming binary32 y + a*x, product and sum each rounded to nearest even.
// ----------------------------------------------------------------------------
// One element pair is taken per clock unless the pipe is held, and the
// result passes four stages in the multiplier (unpack, 24x24 product,
// normalise, round) and four in the adder (align, add, normalise, round).
// The whole pipe advances together and holds while the result register is
// full and the output side is not ready; NaN results come out as 0x7FC00000.
module single_precision_axpy_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [31:0]  cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [63:0]  s_axis_tdata,   // y_value in [63:32], x_value in [31:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // new_y
    output logic        m_axis_tlast
);

    logic [31:0] scale_reg;
    logic        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // pipe moves when the output slot is empty or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic        in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // ---------------- multiplier stage 1: unpack ----------------
    logic        p1_valid_reg, p1_last_reg;
    logic [31:0] p1_y_reg;
    saxpy_pkg::spec_t p1_spec_reg;
    logic        p1_zero_reg;
    logic [9:0]  p1_exp_reg;   // biased exponent sum, offset by bias
    logic [23:0] p1_ma_reg, p1_mb_reg;

    logic [31:0] xv;
    logic [7:0]  ea, eb;
    logic        a_nan, b_nan, a_inf, b_inf, a_z, b_z;
    saxpy_pkg::spec_t mspec;

    always_comb
    begin
        xv = s_axis_tdata[31:0];
        ea = scale_reg[30:23];
        eb = xv[30:23];
        a_nan = (ea == saxpy_pkg::EXP_MAX) && (scale_reg[22:0] != 23'd0);
        b_nan = (eb == saxpy_pkg::EXP_MAX) && (xv[22:0] != 23'd0);
        a_inf = (ea == saxpy_pkg::EXP_MAX) && (scale_reg[22:0] == 23'd0);
        b_inf = (eb == saxpy_pkg::EXP_MAX) && (xv[22:0] == 23'd0);
        a_z   = scale_reg[30:0] == 31'd0;
        b_z   = xv[30:0] == 31'd0;
        mspec.nan  = a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z);
        mspec.inf  = a_inf || b_inf;
        mspec.sign = scale_reg[31] ^ xv[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_last_reg <= s_axis_tlast;
            p1_y_reg    <= s_axis_tdata[63:32];
            p1_spec_reg <= mspec;
            p1_zero_reg <= a_z || b_z;
            p1_exp_reg  <= {2'b00, (ea == 8'd0) ? 8'd1 : ea}
                         + {2'b00, (eb == 8'd0) ? 8'd1 : eb};
            p1_ma_reg   <= {ea != 8'd0, scale_reg[22:0]};
            p1_mb_reg   <= {eb != 8'd0, xv[22:0]};
        end
    end

    // ---------------- multiplier stage 2: product ----------------
    logic        p2_valid_reg, p2_last_reg, p2_zero_reg;
    logic [31:0] p2_y_reg;
    saxpy_pkg::spec_t p2_spec_reg;
    logic [9:0]  p2_exp_reg;
    logic [47:0] p2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_last_reg <= p1_last_reg;
            p2_y_reg    <= p1_y_reg;
            p2_spec_reg <= p1_spec_reg;
            p2_zero_reg <= p1_zero_reg;
            p2_exp_reg  <= p1_exp_reg;
            p2_prod_reg <= p1_ma_reg * p1_mb_reg;
        end
    end

    // ---------------- multiplier stage 3: normalise ----------------
    // value = prod * 2^(exp - 127 - 46); target mantissa 24 bits + grs
    logic        p3_valid_reg, p3_last_reg, p3_zero_reg;
    logic [31:0] p3_y_reg;
    saxpy_pkg::spec_t p3_spec_reg;
    logic [10:0] p3_exp_reg;
    logic [26:0] p3_mant_reg;

    logic [5:0]  lz;
    logic [11:0] e_norm;     // signed, exponent when top bit at 47
    logic [47:0] pn;
    logic [5:0]  rsh;
    logic [74:0] wide;
    logic [10:0] e_out;
    logic [26:0] m_out;

    always_comb
    begin
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (p2_prod_reg[i]) lz = 6'(47 - i);
        end
        pn     = p2_prod_reg << lz;
        // exponent of top bit at position 47: exp - 127 + 1 - lz
        e_norm = 12'({2'b00, p2_exp_reg}) - 12'd126 - 12'({6'd0, lz});
        rsh    = 6'd0;
        e_out  = 11'd0;
        if ($signed(e_norm) >= 12'sd1)
        begin
            e_out = e_norm[10:0];
        end
        else
        begin
            // subnormal: shift right to exponent 1
            rsh   = ($signed(e_norm) < -12'sd30) ? 6'd31 : 6'(12'd1 - e_norm);
            e_out = 11'd0;
        end
        wide  = {pn, 27'd0} >> rsh;
        m_out = {wide[74:49], wide[48:0] != 49'd0};
        if ($signed(e_norm) >= 12'sd1 && $signed(e_norm) > 12'sd300)
            e_out = 11'd300;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_last_reg <= p2_last_reg;
            p3_y_reg    <= p2_y_reg;
            p3_spec_reg <= p2_spec_reg;
            p3_zero_reg <= p2_zero_reg;
            p3_exp_reg  <= e_out;
            p3_mant_reg <= m_out;
        end
    end

    // ---------------- multiplier stage 4: round and pack ----------------
    logic        p4_valid_reg, p4_last_reg;
    logic [31:0] p4_y_reg, p4_prod_reg;

    logic        rnd_up;
    logic [24:0] mant_r;
    logic [10:0] exp_r;
    logic [31:0] prod_c;

    always_comb
    begin
        rnd_up = p3_mant_reg[2] & (p3_mant_reg[1] | p3_mant_reg[0] | p3_mant_reg[3]);
        mant_r = {1'b0, p3_mant_reg[26:3]} + {24'd0, rnd_up};
        exp_r  = p3_exp_reg;
        if (mant_r[24])
        begin
            mant_r = {1'b0, mant_r[24:1]};
            exp_r  = exp_r + 11'd1;
        end
        else if (exp_r == 11'd0 && mant_r[23])
        begin
            exp_r = 11'd1;
        end
        if (p3_spec_reg.nan)
            prod_c = saxpy_pkg::CANON_NAN;
        else if (p3_spec_reg.inf)
            prod_c = {p3_spec_reg.sign, saxpy_pkg::EXP_MAX, 23'd0};
        else if (p3_zero_reg)
            prod_c = {p3_spec_reg.sign, 31'd0};
        else if (exp_r >= 11'd255)
            prod_c = {p3_spec_reg.sign, saxpy_pkg::EXP_MAX, 23'd0};
        else
            prod_c = {p3_spec_reg.sign, exp_r[7:0], mant_r[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_last_reg <= p3_last_reg;
            p4_y_reg    <= p3_y_reg;
            p4_prod_reg <= prod_c;
        end
    end

    // ---------------- adder ----------------
    saxpy_add u_add (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_last   (p4_last_reg),
        .a_in      (p4_y_reg),
        .b_in      (p4_prod_reg),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .sum_out   (m_axis_tdata)
    );

    // ---------------- assertions ----------------
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(p1_valid_reg) && $stable(p4_valid_reg))
        else $error("pipeline advanced during stall");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output");

    a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[30:23] == saxpy_pkg::EXP_MAX
         && m_axis_tdata[22:0] != 23'd0) |-> m_axis_tdata == saxpy_pkg::CANON_NAN)
        else $error("non canonical nan on output");

endmodule
`default_nettype wire

// File: hdl/saxpy_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saxpy_add
// Pipelined binary32 adder, round to nearest even, subnormals kept.
// Four register stages with a stall enable; valid and last travel alongside.
// ----------------------------------------------------------------------------
module saxpy_add (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         en,
    input  wire         in_valid,
    input  wire         in_last,
    input  wire [31:0]  a_in,
    input  wire [31:0]  b_in,
    output logic        out_valid,
    output logic        out_last,
    output logic [31:0] sum_out
);

    // ---------------- stage 1: classify, swap, align ----------------
    logic        s1_valid_reg;
    logic        s1_last_reg;
    saxpy_pkg::spec_t s1_spec_reg;
    logic        s1_sign_l_reg;
    logic        s1_sub_reg;
    logic [7:0]  s1_exp_reg;
    logic [26:0] s1_big_reg;
    logic [26:0] s1_small_reg;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        a_larger;
    logic [7:0]  e_l, e_s, ediff;
    logic [23:0] m_l, m_s;
    logic [49:0] sh_ext;
    logic [26:0] small_al;
    saxpy_pkg::spec_t spec_c;

    always_comb
    begin
        ea = a_in[30:23];
        eb = b_in[30:23];
        // subnormals use exponent 1 with no hidden bit
        ma = {ea != 8'd0, a_in[22:0]};
        mb = {eb != 8'd0, b_in[22:0]};
        if (ea == 8'd0) ea = 8'd1;
        if (eb == 8'd0) eb = 8'd1;
        a_nan = (a_in[30:23] == saxpy_pkg::EXP_MAX) && (a_in[22:0] != 23'd0);
        b_nan = (b_in[30:23] == saxpy_pkg::EXP_MAX) && (b_in[22:0] != 23'd0);
        a_inf = (a_in[30:23] == saxpy_pkg::EXP_MAX) && (a_in[22:0] == 23'd0);
        b_inf = (b_in[30:23] == saxpy_pkg::EXP_MAX) && (b_in[22:0] == 23'd0);
        a_larger = {ea, ma} >= {eb, mb};
        e_l = a_larger ? ea : eb;
        e_s = a_larger ? eb : ea;
        m_l = a_larger ? ma : mb;
        m_s = a_larger ? mb : ma;
        ediff = e_l - e_s;
        sh_ext = {m_s, 26'd0} >> ((ediff > 8'd26) ? 8'd26 : ediff);
        // guard, round and sticky bit below the mantissa
        small_al = (ediff > 8'd26) ? {26'd0, m_s != 24'd0}
                 : {sh_ext[49:24], sh_ext[23:0] != 24'd0};
        spec_c.nan  = a_nan || b_nan || (a_inf && b_inf && (a_in[31] != b_in[31]));
        spec_c.inf  = a_inf || b_inf;
        spec_c.sign = a_inf ? a_in[31] : b_in[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg   <= in_last;
            s1_spec_reg   <= spec_c;
            s1_sign_l_reg <= a_larger ? a_in[31] : b_in[31];
            s1_sub_reg    <= a_in[31] != b_in[31];
            s1_exp_reg    <= e_l;
            s1_big_reg    <= {m_l, 3'd0};
            s1_small_reg  <= small_al;
        end
    end

    // ---------------- stage 2: add or subtract ----------------
    logic        s2_valid_reg;
    logic        s2_last_reg;
    saxpy_pkg::spec_t s2_spec_reg;
    logic        s2_sign_reg;
    logic        s2_sub_reg;
    logic [7:0]  s2_exp_reg;
    logic [27:0] s2_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_last_reg <= s1_last_reg;
            s2_spec_reg <= s1_spec_reg;
            s2_sign_reg <= s1_sign_l_reg;
            s2_sub_reg  <= s1_sub_reg;
            s2_exp_reg  <= s1_exp_reg;
            s2_mag_reg  <= s1_sub_reg ? ({1'b0, s1_big_reg} - {1'b0, s1_small_reg})
                                      : ({1'b0, s1_big_reg} + {1'b0, s1_small_reg});
        end
    end

    // ---------------- stage 3: normalise ----------------
    logic        s3_valid_reg;
    logic        s3_last_reg;
    saxpy_pkg::spec_t s3_spec_reg;
    logic        s3_sign_reg;
    logic        s3_zero_reg;
    logic [9:0]  s3_exp_reg;
    logic [26:0] s3_mant_reg;

    logic [4:0]  lz;
    logic [4:0]  shl;
    logic [27:0] norm;
    logic [9:0]  exp_n;
    logic [26:0] mant_n;

    always_comb
    begin
        lz = 5'd28;
        for (int i = 0; i < 28; i++)
        begin
            if (s2_mag_reg[i]) lz = 5'(27 - i);
        end
        mant_n = 27'd0;
        exp_n  = 10'd0;
        shl    = 5'd0;
        norm   = 28'd0;
        if (s2_mag_reg[27])
        begin
            // carry out: shift right one keeping sticky
            mant_n = {s2_mag_reg[27:2], s2_mag_reg[1] | s2_mag_reg[0]};
            exp_n  = {2'b00, s2_exp_reg} + 10'd1;
        end
        else
        begin
            // shift left by lz-1 but not below exponent 1
            shl = (lz == 5'd0) ? 5'd0 : lz - 5'd1;
            if ({5'd0, shl} >= {2'b00, s2_exp_reg})
                shl = 5'(s2_exp_reg - 8'd1);
            norm   = s2_mag_reg << shl;
            mant_n = norm[26:0];
            exp_n  = {2'b00, s2_exp_reg} - {5'd0, shl};
            if (!norm[26]) exp_n = 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_last_reg <= s2_last_reg;
            s3_spec_reg <= s2_spec_reg;
            // exact cancellation gives +0 unless both operands were negative
            s3_zero_reg <= s2_mag_reg == 28'd0;
            s3_sign_reg <= (s2_mag_reg == 28'd0) ? (s2_sign_reg & ~s2_sub_reg)
                                                 : s2_sign_reg;
            s3_exp_reg  <= exp_n;
            s3_mant_reg <= mant_n;
        end
    end

    // ---------------- stage 4: round and pack ----------------
    logic        s4_valid_reg;
    logic        s4_last_reg;
    logic [31:0] s4_res_reg;

    logic        rnd_up;
    logic [24:0] mant_r;
    logic [9:0]  exp_r;
    logic [31:0] res_c;

    always_comb
    begin
        rnd_up = s3_mant_reg[2] & (s3_mant_reg[1] | s3_mant_reg[0] | s3_mant_reg[3]);
        mant_r = {1'b0, s3_mant_reg[26:3]} + {24'd0, rnd_up};
        exp_r  = s3_exp_reg;
        if (mant_r[24])
        begin
            mant_r = {1'b0, mant_r[24:1]};
            exp_r  = exp_r + 10'd1;
        end
        else if (exp_r == 10'd0 && mant_r[23])
        begin
            exp_r = 10'd1;
        end
        if (s3_spec_reg.nan)
            res_c = saxpy_pkg::CANON_NAN;
        else if (s3_spec_reg.inf)
            res_c = {s3_spec_reg.sign, saxpy_pkg::EXP_MAX, 23'd0};
        else if (s3_zero_reg)
            res_c = {s3_sign_reg, 31'd0};
        else if (exp_r >= 10'd255)
            res_c = {s3_sign_reg, saxpy_pkg::EXP_MAX, 23'd0};
        else
            res_c = {s3_sign_reg, exp_r[7:0], mant_r[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_last_reg <= s3_last_reg;
            s4_res_reg  <= res_c;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_last  = s4_last_reg;
    assign sum_out   = s4_res_reg;

endmodule
`default_nettype wire
